[hw/rtl/bgpm_pkg.sv]
package bgpm_pkg;

    localparam int MASK_W      = 32;
    localparam int CODE_W      = 16;
    localparam int GLYPH_COUNT = 58;
    localparam int GLYPH_IDX_W = $clog2(GLYPH_COUNT);
    // candidate slots, padded to a power of two for the reduction tree
    localparam int CAND_COUNT  = 1 << GLYPH_IDX_W;
    localparam int DIST_W      = $clog2(MASK_W / 2 + 1);

    localparam logic [5:0]        WORST_DIST      = 6'd32;
    localparam logic [5:0]        HALF_DIST       = 6'd16;
    localparam logic [DIST_W-1:0] PAD_DIST        = '1;
    localparam logic [CODE_W-1:0] FULL_BLOCK_CODE = 16'h2588;

    typedef struct packed {
        logic [DIST_W-1:0]      hdist;
        logic                   inv;
        logic [GLYPH_IDX_W-1:0] idx;
    } cand_t;

    localparam logic [MASK_W-1:0] GLYPH_PATTERN [GLYPH_COUNT] = '{
        32'h00000000,
        32'h0000000f, 32'h000000ff, 32'h00000fff,
        32'h0000ffff, 32'h000fffff, 32'h00ffffff,
        32'h0fffffff,
        32'heeeeeeee, 32'hcccccccc, 32'h88888888,
        32'h0000cccc, 32'h00003333, 32'hcccc0000,
        32'hcccc3333, 32'h33330000,
        32'h000ff000, 32'h66666666,
        32'h00077666, 32'h000ee666, 32'h66677000,
        32'h666ee000,
        32'h66677666, 32'h666ee666, 32'h000ff666,
        32'h666ff000, 32'h666ff666,
        32'h000cc000, 32'h00066000, 32'h00033000,
        32'h00066000,
        32'h06600660,
        32'h000f0000, 32'h0000f000, 32'h44444444,
        32'h22222222,
        32'h000e0000, 32'h0000e000, 32'h44440000,
        32'h22220000, 32'h00030000, 32'h00003000,
        32'h00004444, 32'h00002222,
        32'h44444444, 32'h22222222,
        32'h0f000000, 32'h00f00000, 32'h00000f00,
        32'h000000f0,
        32'h00066000,
        32'h11224488, 32'h88442211, 32'h99666699,
        32'h000137f0, 32'h0008cef0, 32'h000fec80,
        32'h000f7310
    };

    localparam logic [CODE_W-1:0] GLYPH_CODE [GLYPH_COUNT] = '{
        16'h00a0,
        16'h2581, 16'h2582, 16'h2583,
        16'h2584, 16'h2585, 16'h2586,
        16'h2587,
        16'h258a, 16'h258c, 16'h258e,
        16'h2596, 16'h2597, 16'h2598,
        16'h259a, 16'h259d,
        16'h2501, 16'h2503,
        16'h250f, 16'h2513, 16'h2517,
        16'h251b,
        16'h2523, 16'h252b, 16'h2533,
        16'h253b, 16'h254b,
        16'h2578, 16'h2579, 16'h257a,
        16'h257b,
        16'h254f,
        16'h2500, 16'h2500, 16'h2502,
        16'h2502,
        16'h2574, 16'h2574, 16'h2575,
        16'h2575, 16'h2576, 16'h2576,
        16'h2577, 16'h2577,
        16'h23a2, 16'h23a5,
        16'h23ba, 16'h23bb, 16'h23bc,
        16'h23bd,
        16'h25aa,
        16'h2571, 16'h2572, 16'h2573,
        16'h25e2, 16'h25e3, 16'h25e4,
        16'h25e5
    };

    // adder tree popcount
    function automatic logic [5:0] popcount32(logic [MASK_W-1:0] v);
        logic [1:0] s1 [16];
        logic [2:0] s2 [8];
        logic [3:0] s3 [4];
        logic [4:0] s4 [2];
        for (int i = 0; i < 16; i++)
        begin
            s1[i] = {1'b0, v[2*i]} + {1'b0, v[2*i+1]};
        end
        for (int i = 0; i < 8; i++)
        begin
            s2[i] = {1'b0, s1[2*i]} + {1'b0, s1[2*i+1]};
        end
        for (int i = 0; i < 4; i++)
        begin
            s3[i] = {1'b0, s2[2*i]} + {1'b0, s2[2*i+1]};
        end
        for (int i = 0; i < 2; i++)
        begin
            s4[i] = {1'b0, s3[2*i]} + {1'b0, s3[2*i+1]};
        end
        return {1'b0, s4[0]} + {1'b0, s4[1]};
    endfunction

    // right side wins only when strictly closer, so earlier entries keep ties
    function automatic cand_t cand_pick(cand_t a, cand_t b);
        return (b.hdist < a.hdist) ? b : a;
    endfunction

endpackage

[hw/rtl/bgpm_mask_if.sv]
interface bgpm_mask_if import bgpm_pkg::*;;
    logic              valid;
    logic              ready;
    logic [MASK_W-1:0] block_mask;

    modport source (output valid, output block_mask, input ready);
    modport sink   (input valid, input block_mask, output ready);
endinterface

[hw/rtl/bgpm_glyph_if.sv]
interface bgpm_glyph_if import bgpm_pkg::*;;
    logic              valid;
    logic              ready;
    logic [CODE_W-1:0] glyph_code;
    logic              inverted_flag;

    modport source (output valid, output glyph_code, output inverted_flag, input ready);
    modport sink   (input valid, input glyph_code, input inverted_flag, output ready);
endinterface

[hw/rtl/block_glyph_pattern_matcher.sv]
// channel | dir | payload                      | handshake
// block   | in  | block_mask[31:0]             | valid/ready
// glyph   | out | glyph_code[15:0], inv flag   | valid/ready
//
// one mask per cycle sustained unless the output stalls; the registers in order:
// input register, distance register, two min stages, output register; the min
// stages and the output register each do two levels of the 64-slot min tree.
// rst_n clears all valid bits asynchronously; payload registers are not reset.
// a stalled output backs up only as far as needed: empty stages keep filling,
// so new beats are taken while a finished result waits.
module block_glyph_pattern_matcher import bgpm_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    bgpm_mask_if.sink    block,
    bgpm_glyph_if.source glyph
);

    localparam int N_A = CAND_COUNT / 4;
    localparam int N_B = CAND_COUNT / 16;

    logic                    v0_reg;
    logic                    v0_next;
    logic [MASK_W-1:0]       mask_reg;
    logic                    take;

    logic                    v1_reg;
    logic                    v1_next;
    cand_t [CAND_COUNT-1:0]  cand1_reg;
    cand_t [CAND_COUNT-1:0]  cand1_next;
    logic                    s1_ready;
    logic                    s1_load;

    logic                    a_ready;
    logic                    a_valid;
    cand_t [N_A-1:0]         a_cands;
    logic                    b_ready;
    logic                    b_valid;
    cand_t [N_B-1:0]         b_cands;

    logic                    vout_reg;
    logic                    vout_next;
    logic                    out_load;
    cand_t                   win;
    logic [CODE_W-1:0]       code_reg;
    logic [CODE_W-1:0]       code_next;
    logic                    inv_reg;

    // input register
    assign block.ready = !v0_reg || s1_ready;
    assign take        = block.valid && block.ready;
    assign v0_next     = take ? 1'b1 : (s1_ready ? 1'b0 : v0_reg);

    // distances: the inverted form is 32 minus the plain one, and wins only
    // past the halfway point since plain is tried first
    for (genvar g = 0; g < CAND_COUNT; g++)
    begin : g_dist
        if (g < GLYPH_COUNT)
        begin : g_real
            logic [5:0] d;
            assign d                   = popcount32(mask_reg ^ GLYPH_PATTERN[g]);
            assign cand1_next[g].inv   = (d > HALF_DIST);
            assign cand1_next[g].hdist = (d > HALF_DIST) ? DIST_W'(WORST_DIST - d)
                                                         : d[DIST_W-1:0];
            assign cand1_next[g].idx   = GLYPH_IDX_W'(g);
        end
        else
        begin : g_pad
            assign cand1_next[g].inv   = 1'b0;
            assign cand1_next[g].hdist = PAD_DIST;
            assign cand1_next[g].idx   = GLYPH_IDX_W'(g);
        end
    end

    assign s1_ready = !v1_reg || a_ready;
    assign s1_load  = v0_reg && s1_ready;
    assign v1_next  = s1_load ? 1'b1 : (a_ready ? 1'b0 : v1_reg);

    bgpm_min_stage #(.N_IN(CAND_COUNT)) u_min_a (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v1_reg),
        .in_ready  (a_ready),
        .in_cands  (cand1_reg),
        .out_valid (a_valid),
        .out_ready (b_ready),
        .out_cands (a_cands)
    );

    logic b_out_ready;

    bgpm_min_stage #(.N_IN(N_A)) u_min_b (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (a_valid),
        .in_ready  (b_ready),
        .in_cands  (a_cands),
        .out_valid (b_valid),
        .out_ready (b_out_ready),
        .out_cands (b_cands)
    );

    // last two tree levels and the code lookup
    assign win = cand_pick(cand_pick(b_cands[0], b_cands[1]),
                           cand_pick(b_cands[2], b_cands[3]));
    assign code_next = (win.idx < GLYPH_IDX_W'(GLYPH_COUNT)) ? GLYPH_CODE[win.idx]
                                                             : FULL_BLOCK_CODE;

    assign b_out_ready = !vout_reg || glyph.ready;
    assign out_load    = b_valid && b_out_ready;
    assign vout_next   = out_load ? 1'b1 : (glyph.ready ? 1'b0 : vout_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg   <= 1'b0;
            v1_reg   <= 1'b0;
            vout_reg <= 1'b0;
        end
        else
        begin
            v0_reg   <= v0_next;
            v1_reg   <= v1_next;
            vout_reg <= vout_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            mask_reg <= block.block_mask;
        end
        if (s1_load)
        begin
            cand1_reg <= cand1_next;
        end
        if (out_load)
        begin
            code_reg <= code_next;
            inv_reg  <= win.inv;
        end
    end

    assign glyph.valid         = vout_reg;
    assign glyph.glyph_code    = code_reg;
    assign glyph.inverted_flag = inv_reg;

    a_take_fills_input: assert property (@(posedge clk) disable iff (!rst_n)
        take |=> v0_reg)
        else $error("accepted beat did not reach the input register");

    a_dist_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
        v1_reg && !a_ready |=> v1_reg && $stable(cand1_reg))
        else $error("distance stage changed while stalled");

    a_winner_in_table: assert property (@(posedge clk) disable iff (!rst_n)
        b_valid |-> win.hdist <= DIST_W'(HALF_DIST) && win.idx < GLYPH_IDX_W'(GLYPH_COUNT))
        else $error("min tree picked a padding slot or an impossible distance");

    a_result_never_default: assert property (@(posedge clk) disable iff (!rst_n)
        vout_reg |-> code_reg != FULL_BLOCK_CODE)
        else $error("result fell back to the full block code");

endmodule

[hw/rtl/bgpm_min_stage.sv]
module bgpm_min_stage import bgpm_pkg::*;
#(
    parameter int N_IN = CAND_COUNT
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  cand_t [N_IN-1:0]       in_cands,
    output logic                   out_valid,
    input  logic                   out_ready,
    output cand_t [N_IN/4-1:0]     out_cands
);

    localparam int N_OUT = N_IN / 4;

    logic               valid_reg;
    logic               valid_next;
    cand_t [N_OUT-1:0]  cands_reg;
    cand_t [N_OUT-1:0]  cands_next;
    logic               load;

    // two tree levels per register
    always_comb
    begin
        for (int j = 0; j < N_OUT; j++)
        begin
            cands_next[j] = cand_pick(cand_pick(in_cands[4*j], in_cands[4*j+1]),
                                      cand_pick(in_cands[4*j+2], in_cands[4*j+3]));
        end
    end

    assign in_ready   = !valid_reg || out_ready;
    assign load       = in_valid && in_ready;
    assign valid_next = load ? 1'b1 : (out_ready ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            cands_reg <= cands_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_cands = cands_reg;

endmodule

[verif/block_glyph_pattern_matcher_test.sv]
module block_glyph_pattern_matcher_test import bgpm_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int              SHAPE_COUNT  = 58;
    localparam int              FAR_DIST     = 32;
    localparam logic [15:0]     SOLID_GLYPH  = 16'h2588;
    localparam int              CYCLE_LIMIT  = 100000;
    localparam int              SETTLE_CYCLES = 12;
    localparam int              PRINT_LIMIT  = 40;

    localparam logic [31:0] SHAPE_BITS [SHAPE_COUNT] = '{
        32'h00000000,
        32'h0000000f, 32'h000000ff, 32'h00000fff,
        32'h0000ffff, 32'h000fffff, 32'h00ffffff,
        32'h0fffffff,
        32'heeeeeeee, 32'hcccccccc, 32'h88888888,
        32'h0000cccc, 32'h00003333, 32'hcccc0000,
        32'hcccc3333, 32'h33330000,
        32'h000ff000, 32'h66666666,
        32'h00077666, 32'h000ee666, 32'h66677000,
        32'h666ee000,
        32'h66677666, 32'h666ee666, 32'h000ff666,
        32'h666ff000, 32'h666ff666,
        32'h000cc000, 32'h00066000, 32'h00033000,
        32'h00066000,
        32'h06600660,
        32'h000f0000, 32'h0000f000, 32'h44444444,
        32'h22222222,
        32'h000e0000, 32'h0000e000, 32'h44440000,
        32'h22220000, 32'h00030000, 32'h00003000,
        32'h00004444, 32'h00002222,
        32'h44444444, 32'h22222222,
        32'h0f000000, 32'h00f00000, 32'h00000f00,
        32'h000000f0,
        32'h00066000,
        32'h11224488, 32'h88442211, 32'h99666699,
        32'h000137f0, 32'h0008cef0, 32'h000fec80,
        32'h000f7310
    };

    localparam logic [15:0] SHAPE_GLYPH [SHAPE_COUNT] = '{
        16'h00a0,
        16'h2581, 16'h2582, 16'h2583,
        16'h2584, 16'h2585, 16'h2586,
        16'h2587,
        16'h258a, 16'h258c, 16'h258e,
        16'h2596, 16'h2597, 16'h2598,
        16'h259a, 16'h259d,
        16'h2501, 16'h2503,
        16'h250f, 16'h2513, 16'h2517,
        16'h251b,
        16'h2523, 16'h252b, 16'h2533,
        16'h253b, 16'h254b,
        16'h2578, 16'h2579, 16'h257a,
        16'h257b,
        16'h254f,
        16'h2500, 16'h2500, 16'h2502,
        16'h2502,
        16'h2574, 16'h2574, 16'h2575,
        16'h2575, 16'h2576, 16'h2576,
        16'h2577, 16'h2577,
        16'h23a2, 16'h23a5,
        16'h23ba, 16'h23bb, 16'h23bc,
        16'h23bd,
        16'h25aa,
        16'h2571, 16'h2572, 16'h2573,
        16'h25e2, 16'h25e3, 16'h25e4,
        16'h25e5
    };

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic              inv;
    } glyph_pick_t;

    logic clk;
    logic rst_n;

    bgpm_mask_if  mask_ch ();
    bgpm_glyph_if glyph_ch ();

    block_glyph_pattern_matcher u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .block (mask_ch.sink),
        .glyph (glyph_ch.source)
    );

    glyph_pick_t glyph_expect_q [$];
    int          error_count;
    int          cycle_count;
    int          send_idle_pct;
    int          recv_stall_pct;
    int          recv_hold_left;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // nearest glyph by hamming distance, first strict minimum wins
    function automatic glyph_pick_t nearest_glyph(input logic [MASK_W-1:0] m);
        int          best;
        int          d;
        glyph_pick_t pick;
        best      = FAR_DIST;
        pick.code = SOLID_GLYPH;
        pick.inv  = 1'b0;
        for (int i = 0; i < SHAPE_COUNT; i++)
        begin
            d = $countones(SHAPE_BITS[i] ^ m);
            if (d < best)
            begin
                best      = d;
                pick.code = SHAPE_GLYPH[i];
                pick.inv  = 1'b0;
            end
            d = $countones(~SHAPE_BITS[i] ^ m);
            if (d < best)
            begin
                best      = d;
                pick.code = SHAPE_GLYPH[i];
                pick.inv  = 1'b1;
            end
        end
        return pick;
    endfunction

    task automatic report_mismatch(input string msg);
        error_count++;
        if (error_count <= PRINT_LIMIT)
        begin
            $display("[%0t] mismatch: %s", $realtime, msg);
        end
    endtask

    // called at a falling edge, returns at a falling edge with valid still high
    task automatic send_mask(input logic [MASK_W-1:0] m);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            mask_ch.valid <= 1'b0;
            @(negedge clk);
        end
        mask_ch.valid      <= 1'b1;
        mask_ch.block_mask <= m;
        do
            @(posedge clk);
        while (!mask_ch.ready);
        glyph_expect_q = {glyph_expect_q, nearest_glyph(m)};
        @(negedge clk);
    endtask

    // one case in four is a table shape, maybe inverted, with up to four flipped pixels, so near ties get exercised
    function automatic logic [MASK_W-1:0] random_mask();
        logic [MASK_W-1:0] m;
        int                flips;
        case ($urandom_range(3))
            0: m = $urandom();
            1:
            begin
                m = SHAPE_BITS[$urandom_range(SHAPE_COUNT - 1)];
                if ($urandom_range(1))
                begin
                    m = ~m;
                end
                flips = $urandom_range(4);
                for (int k = 0; k < flips; k++)
                begin
                    m[$urandom_range(MASK_W - 1)] ^= 1'b1;
                end
            end
            2: m = $urandom() & $urandom() & $urandom();
            default: m = $urandom() | $urandom() | $urandom();
        endcase
        return m;
    endfunction

    task automatic test_directed();
        logic [MASK_W-1:0] masks [$];
        masks = {
            32'h00000000, 32'hffffffff, 32'h80000000, 32'h00000001,
            32'haaaaaaaa, 32'h55555555, 32'h0000ffff, 32'hffff0000,
            32'hcccccccc, 32'h33333333, 32'h00066000, 32'hfff99fff,
            32'h44444444, 32'h22222222, 32'h0000f000, 32'h000f7310,
            32'hfff08cef, 32'h99666699, 32'h11224489, 32'h0fffffff,
            32'h0000ff00, 32'h00ff0000
        };
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        foreach (masks[i])
        begin
            send_mask(masks[i]);
        end
    endtask

    task automatic test_random(input int count, input int idle_pct, input int stall_pct);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int n = 0; n < count; n++)
        begin
            send_mask(random_mask());
        end
    endtask

    // long receiver hold while beats keep coming, so the pipe fills and blocks input
    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        recv_hold_left = 80;
        for (int n = 0; n < 60; n++)
        begin
            send_mask(random_mask());
        end
    endtask

    initial
    begin
        glyph_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (recv_hold_left > 0)
            begin
                glyph_ch.ready <= 1'b0;
                recv_hold_left--;
            end
            else
            begin
                glyph_ch.ready <= !(recv_stall_pct != 0 &&
                                    $urandom_range(99) < recv_stall_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        glyph_pick_t want;
        if (rst_n && glyph_ch.valid && glyph_ch.ready)
        begin
            if (glyph_expect_q.size() == 0)
            begin
                report_mismatch($sformatf("unexpected glyph beat code=%h inv=%b",
                                          glyph_ch.glyph_code, glyph_ch.inverted_flag));
            end
            else
            begin
                want = glyph_expect_q.pop_front();
                if (glyph_ch.glyph_code !== want.code)
                begin
                    report_mismatch($sformatf("glyph_code got %h want %h",
                                              glyph_ch.glyph_code, want.code));
                end
                if (glyph_ch.inverted_flag !== want.inv)
                begin
                    report_mismatch($sformatf("inverted_flag got %b want %b (code %h)",
                                              glyph_ch.inverted_flag, want.inv, want.code));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d beats outstanding",
                     cycle_count, glyph_expect_q.size());
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        error_count        = 0;
        cycle_count        = 0;
        send_idle_pct      = 0;
        recv_stall_pct     = 0;
        recv_hold_left     = 0;
        rst_n              = 1'b0;
        mask_ch.valid      = 1'b0;
        mask_ch.block_mask = '0;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        test_random(340, 0, 0);
        test_random(340, 62, 0);
        test_random(340, 0, 62);
        test_backpressure();
        test_random(350, 17, 17);

        mask_ch.valid  <= 1'b0;
        recv_stall_pct = 0;
        while (glyph_expect_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (error_count == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
